@@ rtl/wglra_pkg.sv @@
// Package for the window gap log-ratio accumulator.
// Holds shared constants, types and the chunk-tracker to log-unit request struct.
package wglra_pkg;

  localparam int unsigned MaxChunk    = 32;
  localparam int unsigned LogFracBits = 16;
  localparam int unsigned L2Fb        = 28;
  localparam int unsigned BucketAw    = $clog2(MaxChunk + 1);
  localparam int unsigned ShiftAmt    = L2Fb + 30 - LogFracBits;

  localparam logic [5:0]  ChunkGapsReset = 6'd10;
  localparam logic [29:0] Ln2Q30         = 30'd744261118;
  localparam logic [21:0] LogOutMax      = 22'h3FFFFF;
  localparam logic [47:0] CountMax       = 48'hFFFF_FFFF_FFFF;

  // Request from the chunk tracker to the log unit.
  typedef struct packed {
    logic [63:0]         hi;
    logic [63:0]         lo;
    logic [BucketAw-1:0] bucket;
  } lr_req_t;

  typedef enum logic [2:0] {
    LogIdle,
    LogNorm,
    LogSquare,
    LogMul,
    LogRound
  } log_state_e;

  typedef enum logic [2:0] {
    TopClear,
    TopIdle,
    TopLog,
    TopRead,
    TopWrite
  } top_state_e;

endpackage

@@ rtl/wglra_log_unit.sv @@
// Iterative ln(hi/lo) unit: leading-one search, 28 squaring rounds per operand,
// then multiply by ln2 and round. Depends on wglra_pkg.
module wglra_log_unit
  import wglra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] hi_i,
  input  logic [63:0] lo_i,
  output logic        done_o,
  output logic [21:0] result_o
);

  log_state_e state_q, state_d;
  logic [63:0] x_q, x_d;
  logic [63:0] y_q, y_d;
  logic [5:0]  ex_q, ex_d;
  logic [5:0]  ey_q, ey_d;
  logic [31:0] mx_q, mx_d;
  logic [31:0] my_q, my_d;
  logic [27:0] fx_q, fx_d;
  logic [27:0] fy_q, fy_d;
  logic [4:0]  rnd_q, rnd_d;
  logic [63:0] prod_q, prod_d;
  logic [21:0] res_q, res_d;

  logic [63:0] sqx, sqy;
  logic [33:0] ax, ay, dd;
  logic [63:0] rounded;

  // Squares of both mantissas, one round per cycle.
  assign sqx = {32'd0, mx_q} * {32'd0, mx_q};
  assign sqy = {32'd0, my_q} * {32'd0, my_q};
  assign ax  = {ex_q, fx_q};
  assign ay  = {ey_q, fy_q};
  assign dd  = (ax > ay) ? (ax - ay) : 34'd0;
  assign rounded = (prod_q + (64'd1 << (ShiftAmt - 1))) >> ShiftAmt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LogIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;  y_q <= y_d;  ex_q <= ex_d;  ey_q <= ey_d;
    mx_q <= mx_d; my_q <= my_d; fx_q <= fx_d; fy_q <= fy_d;
    rnd_q <= rnd_d; prod_q <= prod_d; res_q <= res_d;
  end

  // Sequencer: normalize one bit a cycle, square, multiply, round.
  always_comb begin
    state_d = state_q;
    x_d = x_q;  y_d = y_q;  ex_d = ex_q;  ey_d = ey_q;
    mx_d = mx_q; my_d = my_q; fx_d = fx_q; fy_d = fy_q;
    rnd_d = rnd_q; prod_d = prod_q; res_d = res_q;
    done_o = 1'b0;
    unique case (state_q)
      LogIdle: begin
        if (start_i) begin
          x_d = hi_i;
          y_d = lo_i;
          ex_d = 6'd63;
          ey_d = 6'd63;
          state_d = LogNorm;
        end
      end
      LogNorm: begin
        if (!x_q[63]) begin
          x_d = x_q << 1;
          ex_d = ex_q - 6'd1;
        end
        if (!y_q[63]) begin
          y_d = y_q << 1;
          ey_d = ey_q - 6'd1;
        end
        if (x_q[63] && y_q[63]) begin
          mx_d = x_q[63:32];
          my_d = y_q[63:32];
          fx_d = '0;
          fy_d = '0;
          rnd_d = 5'd27;
          state_d = LogSquare;
        end
      end
      LogSquare: begin
        if (sqx[63]) begin
          fx_d[rnd_q] = 1'b1;
          mx_d = sqx[63:32];
        end else begin
          mx_d = sqx[62:31];
        end
        if (sqy[63]) begin
          fy_d[rnd_q] = 1'b1;
          my_d = sqy[63:32];
        end else begin
          my_d = sqy[62:31];
        end
        rnd_d = rnd_q - 5'd1;
        if (rnd_q == 5'd0) begin
          state_d = LogMul;
        end
      end
      LogMul: begin
        prod_d = {30'd0, dd} * {34'd0, Ln2Q30};
        state_d = LogRound;
      end
      LogRound: begin
        res_d = (rounded > {42'd0, LogOutMax}) ? LogOutMax : rounded[21:0];
        done_o = 1'b1;
        state_d = LogIdle;
      end
      default: state_d = LogIdle;
    endcase
  end

  assign result_o = res_d;

endmodule

@@ rtl/wglra_bucket_mem.sv @@
// Bucket store: one synchronous memory holding sum and count per chunk size.
// Depends on wglra_pkg.
module wglra_bucket_mem
  import wglra_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [BucketAw-1:0] waddr_i,
  input  logic [111:0]        wdata_i,
  input  logic [BucketAw-1:0] raddr_i,
  output logic [111:0]        rdata_o
);

  logic [111:0] mem_q [MaxChunk+1];
  logic [111:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/window_gap_log_ratio_accumulator_top.sv @@
// Window gap log-ratio accumulator, top level. Depends on wglra_pkg,
// wglra_log_unit and wglra_bucket_mem.
//
// A prime that does not close a chunk is taken without a stall. A prime that closes a
// chunk with a nonzero smallest gap starts the log unit (a start, normalization one bit
// at a time until both gaps have their leading one at the top, 28 squaring rounds, a
// multiply and a round), then a bucket memory read and a write-back that also loads
// the result register. After the transfer of such a prime the input stalls until that
// write-back, and also for as long as the previous result still waits on a stalled
// output. After reset the bucket memory is cleared one entry a cycle, entries 0 to 32,
// before the first prime is accepted.
module window_gap_log_ratio_accumulator_top
  import wglra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] prime_value_i,
  input  logic        last_of_window_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] log_ratio_o,
  output logic [63:0] bucket_sum_o,
  output logic [47:0] bucket_count_o
);

  top_state_e state_q, state_d;
  logic [5:0]  chunk_gaps_q;
  logic [63:0] prev_q, prev_d;
  logic [5:0]  pos_q, pos_d;
  logic [63:0] big_q, big_d;
  logic [63:0] sml_q, sml_d;
  lr_req_t     req_q, req_d;
  logic [BucketAw-1:0] clr_q, clr_d;
  logic [21:0] lr_q, lr_d;
  logic        ov_q, ov_d;
  logic [21:0] olr_q, olr_d;
  logic [63:0] osum_q, osum_d;
  logic [47:0] ocnt_q, ocnt_d;

  logic        accept, log_start, log_done;
  logic [21:0] log_res;
  logic        we;
  logic [BucketAw-1:0] waddr;
  logic [111:0] wdata, rdata;
  logic [63:0] gap, nsum;
  logic [64:0] sum_ext;
  logic [47:0] ncnt;
  logic [5:0]  npos;
  logic        range_ok;

  wglra_log_unit u_log (
    .clk_i, .rst_ni,
    .start_i (log_start),
    .hi_i    (req_q.hi),
    .lo_i    (req_q.lo),
    .done_o  (log_done),
    .result_o(log_res)
  );

  wglra_bucket_mem u_mem (
    .clk_i,
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(req_q.bucket),
    .rdata_o(rdata)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_gaps_q <= ChunkGapsReset;
    end else if (cfg_we_i) begin
      chunk_gaps_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TopClear;
      prev_q <= '0; pos_q <= '0; big_q <= '0; sml_q <= '0;
      clr_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q <= prev_d; pos_q <= pos_d; big_q <= big_d; sml_q <= sml_d;
      clr_q <= clr_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; lr_q <= lr_d;
    olr_q <= olr_d; osum_q <= osum_d; ocnt_q <= ocnt_d;
  end

  assign in_stall_o = (state_q != TopIdle);
  assign accept     = in_valid_i && (state_q == TopIdle);
  assign gap        = prime_value_i - prev_q;
  assign range_ok   = (chunk_gaps_q >= 6'd2) && (chunk_gaps_q <= 6'(MaxChunk));
  assign npos       = (pos_q < 6'd63) ? (pos_q + 6'd1) : pos_q;
  assign sum_ext    = {1'b0, rdata[111:48]} + {43'd0, lr_q};
  assign nsum       = sum_ext[64] ? '1 : sum_ext[63:0];
  assign ncnt       = (rdata[47:0] < CountMax) ? (rdata[47:0] + 48'd1) : rdata[47:0];

  // Chunk tracking, log launch and bucket read-modify-write.
  always_comb begin
    state_d = state_q;
    prev_d = prev_q; pos_d = pos_q; big_d = big_q; sml_d = sml_q;
    req_d = req_q; clr_d = clr_q; lr_d = lr_q;
    ov_d = ov_q; olr_d = olr_q; osum_d = osum_q; ocnt_d = ocnt_q;
    log_start = 1'b0;
    we = 1'b0;
    waddr = req_q.bucket;
    wdata = {nsum, ncnt};
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      TopClear: begin
        we = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == BucketAw'(MaxChunk)) begin
          state_d = TopIdle;
        end
      end
      TopIdle: begin
        if (accept) begin
          prev_d = prime_value_i;
          if (!range_ok) begin
            pos_d = '0; big_d = '0; sml_d = '0;
          end else if (pos_q == 6'd0) begin
            pos_d = 6'd1; big_d = '0; sml_d = '0;
          end else begin
            if (pos_q == 6'd1 || gap > big_q) big_d = gap;
            if (pos_q == 6'd1 || gap < sml_q) sml_d = gap;
            pos_d = npos;
            if ({1'b0, npos} >= {1'b0, chunk_gaps_q} + 7'd1) begin
              if (sml_d != 64'd0) begin
                req_d.hi = big_d;
                req_d.lo = sml_d;
                req_d.bucket = BucketAw'(chunk_gaps_q);
                state_d = TopLog;
              end
              pos_d = '0; big_d = '0; sml_d = '0;
            end
          end
          if (last_of_window_i) begin
            pos_d = '0; big_d = '0; sml_d = '0;
          end
        end
      end
      TopLog: begin
        log_start = 1'b1;
        if (log_done) begin
          lr_d = log_res;
          state_d = TopRead;
        end
      end
      TopRead: begin
        state_d = TopWrite;
      end
      // Write back and load the result once the output register is free.
      TopWrite: begin
        if (!ov_q || !out_stall_i) begin
          we = 1'b1;
          olr_d = lr_q;
          osum_d = nsum;
          ocnt_d = ncnt;
          ov_d = 1'b1;
          state_d = TopIdle;
        end
      end
      default: state_d = TopIdle;
    endcase
  end

  assign out_valid_o    = ov_q;
  assign log_ratio_o    = olr_q;
  assign bucket_sum_o   = osum_q;
  assign bucket_count_o = ocnt_q;

endmodule
